FILE: rtl/core/bwsel_pkg.sv
// Shared types and constants for the top-4 bone weight selector.
// No dependencies; imported by every module of the block.
`default_nettype none
package bwsel_pkg;

  localparam int IDX_W     = 8;   // bone index width
  localparam int WGT_W     = 16;  // Q1.15 weight width
  localparam int CNT_W     = 3;   // influence count width
  localparam int OUT_SLOTS = 4;   // slots in one result
  localparam int Q_STEPS   = 16;  // quotient bits per normalize divide
  localparam int STEP_W    = $clog2(Q_STEPS + 1);

  // One chain entry as seen by its downstream neighbor.
  typedef struct packed {
    logic             vld;
    logic [WGT_W-1:0] w;
    logic [IDX_W-1:0] idx;
    logic             ge;   // stored weight >= incoming weight
  } bwsel_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FINISH,
    ST_NORM,
    ST_OUT
  } bwsel_state_t;

endpackage
`default_nettype wire

FILE: rtl/core/bwsel_cell.sv
// One entry of the sorted insertion chain.
// Depends on bwsel_pkg (link struct, field widths).
`default_nettype none
module bwsel_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ins,
  input  logic                       clr,
  input  logic [bwsel_pkg::WGT_W-1:0] new_w,
  input  logic [bwsel_pkg::IDX_W-1:0] new_idx,
  input  bwsel_pkg::bwsel_link_t     prev_lnk,
  output bwsel_pkg::bwsel_link_t     lnk
);
  import bwsel_pkg::*;

  logic             vld_r, vld_nxt;
  logic [WGT_W-1:0] w_r, w_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ge;
  logic             take;

  // ties keep the older entry ahead
  assign ge   = vld_r && (w_r >= new_w);
  assign take = ins && !ge;

  always_comb begin
    vld_nxt = vld_r;
    w_nxt   = w_r;
    idx_nxt = idx_r;
    if (clr) begin
      vld_nxt = 1'b0;
    end else if (take) begin
      if (prev_lnk.ge) begin
        // insertion point
        vld_nxt = 1'b1;
        w_nxt   = new_w;
        idx_nxt = new_idx;
      end else begin
        // shift down from neighbor
        vld_nxt = prev_lnk.vld;
        w_nxt   = prev_lnk.w;
        idx_nxt = prev_lnk.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    idx_r <= idx_nxt;
  end

  assign lnk = '{vld: vld_r, w: w_r, idx: idx_r, ge: ge};

endmodule
`default_nettype wire

FILE: rtl/core/bwsel_div.sv
// Radix-2 restoring divider: quo = dvd_w * 32768 / dvs, one bit per cycle.
// Depends on bwsel_pkg (widths, step count). Requires dvd_w <= dvs, dvs != 0.
`default_nettype none
module bwsel_div #(
  parameter int SUM_W = 19
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bwsel_pkg::WGT_W-1:0] dvd_w,
  input  logic [SUM_W-1:0]            dvs,
  output logic                        busy,
  output logic [bwsel_pkg::WGT_W-1:0] quo
);
  import bwsel_pkg::*;

  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  dvs_r, dvs_nxt;
  logic [WGT_W-1:0]  q_r, q_nxt;
  logic              w0_r, w0_nxt;
  logic              nb;
  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    dvs_ext;

  // dividend is w << 15: high part seeds the remainder, w[0] is the first
  // bit brought down, the rest are zero
  assign nb      = (cnt_r == STEP_W'(Q_STEPS)) ? w0_r : 1'b0;
  assign trial   = {rem_r, nb};
  assign dvs_ext = {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    q_nxt   = q_r;
    w0_nxt  = w0_r;
    if (start) begin
      cnt_nxt = STEP_W'(Q_STEPS);
      rem_nxt = SUM_W'(dvd_w[WGT_W-1:1]);
      dvs_nxt = dvs;
      q_nxt   = '0;
      w0_nxt  = dvd_w[0];
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - STEP_W'(1);
      if (trial >= dvs_ext) begin
        rem_nxt = SUM_W'(trial - dvs_ext);
        q_nxt   = {q_r[WGT_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SUM_W-1:0];
        q_nxt   = {q_r[WGT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
    w0_r  <= w0_nxt;
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;

endmodule
`default_nettype wire

FILE: rtl/core/top4_bone_weight_selector.sv
// Top level of the top-4 bone weight selector.
// Depends on bwsel_pkg, bwsel_cell (insertion chain) and bwsel_div (normalizer).
`default_nettype none
// Influence requests of one vertex stream in at one per cycle into a chain of
// MAX_INFLUENCES cells kept sorted by weight, largest first (a tie keeps the
// earlier bone ahead). A running sum of the kept weights is updated on every
// insert. After the request carrying last_of_vertex the block stops taking
// input: the chain settles in ST_FINISH, then, only when more than
// MAX_INFLUENCES valid influences arrived and the sum is nonzero, four parallel
// bit-serial dividers compute weight*32768/sum (16 quotient bits) in ST_NORM,
// and ST_OUT loads the result register. The result register lets a finished
// vertex wait for out_ready while the next vertex streams in; input stalls
// from each vertex end until its result is loaded, and longer if the previous
// result has not been taken yet. Unused slots read zero.
// Bones at or above MAX_BONES are dropped and not counted.
module top4_bone_weight_selector #(
  parameter int MAX_BONES      = 256,
  parameter int MAX_INFLUENCES = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bwsel_pkg::IDX_W-1:0] in_bone_index,
  input  logic [bwsel_pkg::WGT_W-1:0] in_weight,
  input  logic                        in_has_pair,
  input  logic                        in_last_of_vertex,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bwsel_pkg::IDX_W-1:0] out_index_slot0,
  output logic [bwsel_pkg::IDX_W-1:0] out_index_slot1,
  output logic [bwsel_pkg::IDX_W-1:0] out_index_slot2,
  output logic [bwsel_pkg::IDX_W-1:0] out_index_slot3,
  output logic [bwsel_pkg::WGT_W-1:0] out_weight_slot0,
  output logic [bwsel_pkg::WGT_W-1:0] out_weight_slot1,
  output logic [bwsel_pkg::WGT_W-1:0] out_weight_slot2,
  output logic [bwsel_pkg::WGT_W-1:0] out_weight_slot3,
  output logic [bwsel_pkg::CNT_W-1:0] out_influence_count
);
  import bwsel_pkg::*;

  // sum of up to MAX_INFLUENCES 16-bit weights
  localparam int SUM_W  = WGT_W + $clog2(MAX_INFLUENCES + 1);
  // pairs seen saturates at MAX_INFLUENCES + 1
  localparam int SEEN_W = $clog2(MAX_INFLUENCES + 2);
  localparam logic [SEEN_W-1:0] MAX_SEEN = SEEN_W'(MAX_INFLUENCES);
  localparam logic [16:0]       BONE_LIM = 17'(MAX_BONES);
  localparam bwsel_link_t CHAIN_HEAD = '{vld: 1'b0, w: '0, idx: '0, ge: 1'b1};

  bwsel_state_t state_r, state_nxt;

  logic in_acc;
  logic pair_ok;
  logic ins;
  logic chain_clr;
  logic div_start;
  logic out_load;
  logic renorm;
  logic sum_zero;

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;

  bwsel_link_t lnk [MAX_INFLUENCES];
  bwsel_link_t last_lnk;

  logic             slot_vld [OUT_SLOTS];
  logic [WGT_W-1:0] slot_w   [OUT_SLOTS];
  logic [IDX_W-1:0] slot_idx [OUT_SLOTS];
  logic [WGT_W-1:0] slot_q   [OUT_SLOTS];
  logic [OUT_SLOTS-1:0] slot_busy;
  logic             div_busy;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r [OUT_SLOTS];
  logic [WGT_W-1:0] out_wgt_r [OUT_SLOTS];
  logic [CNT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0] cnt_now;

  assign in_acc  = in_valid && in_ready;
  assign pair_ok = in_has_pair && ({9'd0, in_bone_index} < BONE_LIM);
  assign ins     = in_acc && pair_ok;

  // ---------------------------------------------------------------- chain
  genvar c;
  generate
    for (c = 0; c < MAX_INFLUENCES; c++) begin : g_cell
      if (c == 0) begin : g_head
        bwsel_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ins      (ins),
          .clr      (chain_clr),
          .new_w    (in_weight),
          .new_idx  (in_bone_index),
          .prev_lnk (CHAIN_HEAD),
          .lnk      (lnk[c])
        );
      end else begin : g_body
        bwsel_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .ins      (ins),
          .clr      (chain_clr),
          .new_w    (in_weight),
          .new_idx  (in_bone_index),
          .prev_lnk (lnk[c-1]),
          .lnk      (lnk[c])
        );
      end
    end
  endgenerate

  assign last_lnk = lnk[MAX_INFLUENCES-1];

  // Running sum: add the new weight, drop the tail entry if it falls off.
  // A full chain whose tail is >= the new weight takes nothing.
  always_comb begin
    sum_nxt  = sum_r;
    seen_nxt = seen_r;
    if (chain_clr) begin
      sum_nxt  = '0;
      seen_nxt = '0;
    end else if (ins) begin
      if (!last_lnk.ge) begin
        sum_nxt = sum_r + SUM_W'(in_weight)
                - (last_lnk.vld ? SUM_W'(last_lnk.w) : SUM_W'(0));
      end
      if (seen_r <= MAX_SEEN) begin
        seen_nxt = seen_r + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      seen_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      seen_r <= seen_nxt;
    end
  end

  assign renorm   = (seen_r > MAX_SEEN);
  assign sum_zero = (sum_r == '0);

  // ------------------------------------------------------ slots + dividers
  genvar s;
  generate
    for (s = 0; s < OUT_SLOTS; s++) begin : g_slot
      if (s < MAX_INFLUENCES) begin : g_used
        assign slot_vld[s] = lnk[s].vld;
        assign slot_w[s]   = lnk[s].w;
        assign slot_idx[s] = lnk[s].idx;
      end else begin : g_none
        assign slot_vld[s] = 1'b0;
        assign slot_w[s]   = '0;
        assign slot_idx[s] = '0;
      end

      bwsel_div #(
        .SUM_W (SUM_W)
      ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd_w (slot_w[s]),
        .dvs   (sum_r),
        .busy  (slot_busy[s]),
        .quo   (slot_q[s])
      );
    end
  endgenerate

  assign div_busy = |slot_busy;

  // filled slots, valid entries form a prefix
  always_comb begin
    cnt_now = '0;
    for (int k = 0; k < OUT_SLOTS; k++) begin
      cnt_now = cnt_now + CNT_W'(slot_vld[k]);
    end
  end

  // ------------------------------------------------------------------ FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    chain_clr = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_last_of_vertex) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (renorm && !sum_zero) begin
          div_start = 1'b1;
          state_nxt = ST_NORM;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_NORM: begin
        if (!div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          chain_clr = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // -------------------------------------------------------- result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int k = 0; k < OUT_SLOTS; k++) begin
        if (!slot_vld[k]) begin
          out_idx_r[k] <= '0;
          out_wgt_r[k] <= '0;
        end else begin
          out_idx_r[k] <= slot_idx[k];
          if (!renorm) begin
            out_wgt_r[k] <= slot_w[k];
          end else if (sum_zero) begin
            out_wgt_r[k] <= '0;
          end else begin
            out_wgt_r[k] <= slot_q[k];
          end
        end
      end
      out_cnt_r <= cnt_now;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_index_slot0     = out_idx_r[0];
  assign out_index_slot1     = out_idx_r[1];
  assign out_index_slot2     = out_idx_r[2];
  assign out_index_slot3     = out_idx_r[3];
  assign out_weight_slot0    = out_wgt_r[0];
  assign out_weight_slot1    = out_wgt_r[1];
  assign out_weight_slot2    = out_wgt_r[2];
  assign out_weight_slot3    = out_wgt_r[3];
  assign out_influence_count = out_cnt_r;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for top4_bone_weight_selector.
// Needs bwsel_pkg and the RTL of the block. Drives influence requests with random
// idling and compares every vertex result with a top-4 chain predictor or a typed row.
`default_nettype none
module tb;
  import bwsel_pkg::*;

  localparam int MAX_BONES    = 256;
  localparam int MAX_INFL     = 4;
  localparam int N_DIR        = 25;
  localparam int TARGET_REQS  = 1350;
  // Slowest honest run: ~1400 requests, each after the longest drawn wait,
  // plus the longest output stall and the finish and renormalize per vertex;
  // this is several times that.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;    // covers settle + 16-step divide + load
  localparam int PRINT_CAP    = 40;
  localparam logic [WGT_W-1:0] Q15_ONE = 16'd32768;

  // One vertex result as it appears on the out_ port group.
  // Packed slot arrays: element 0 sits in the low bits, so {s3,s2,s1,s0}.
  typedef struct packed {
    logic [OUT_SLOTS-1:0][IDX_W-1:0] idx;
    logic [OUT_SLOTS-1:0][WGT_W-1:0] wgt;
    logic [CNT_W-1:0]                cnt;
  } vertex_result_t;

  // Directed stimulus row; fixed_res marks a last request whose result is
  // typed in by hand instead of taken from the predictor.
  typedef struct packed {
    logic [IDX_W-1:0] bone;
    logic [WGT_W-1:0] wgt;
    logic             has_pair;
    logic             end_vtx;
    logic             fixed_res;
    vertex_result_t   res;
  } influence_row_t;

  localparam influence_row_t DIR_ROWS [N_DIR] = '{
    // empty vertex: count 0, every slot zero
    '{8'd0,   16'd0,     1'b0, 1'b1, 1'b1, '0},
    // single influence at the top extremes of both fields
    '{8'd255, 16'd32768, 1'b1, 1'b1, 1'b1,
      '{{8'd0, 8'd0, 8'd0, 8'd255}, {16'd0, 16'd0, 16'd0, 16'd32768}, 3'd1}},
    // single influence at the bottom extremes
    '{8'd0,   16'd0,     1'b1, 1'b1, 1'b1,
      '{{8'd0, 8'd0, 8'd0, 8'd0}, {16'd0, 16'd0, 16'd0, 16'd0}, 3'd1}},
    // weight above 1.0 passes through untouched without renormalize
    '{8'd7,   16'd65535, 1'b1, 1'b1, 1'b1,
      '{{8'd0, 8'd0, 8'd0, 8'd7}, {16'd0, 16'd0, 16'd0, 16'd65535}, 3'd1}},
    // equal weights: the earlier bone stays ahead
    '{8'd1,   16'd100,   1'b1, 1'b0, 1'b0, '0},
    '{8'd2,   16'd100,   1'b1, 1'b1, 1'b1,
      '{{8'd0, 8'd0, 8'd2, 8'd1}, {16'd0, 16'd0, 16'd100, 16'd100}, 3'd2}},
    // five equal weights: the tie cannot displace a full chain; sum is 1.0
    '{8'd10,  16'd8192,  1'b1, 1'b0, 1'b0, '0},
    '{8'd11,  16'd8192,  1'b1, 1'b0, 1'b0, '0},
    '{8'd12,  16'd8192,  1'b1, 1'b0, 1'b0, '0},
    '{8'd13,  16'd8192,  1'b1, 1'b0, 1'b0, '0},
    '{8'd14,  16'd8192,  1'b1, 1'b1, 1'b1,
      '{{8'd13, 8'd12, 8'd11, 8'd10}, {16'd8192, 16'd8192, 16'd8192, 16'd8192}, 3'd4}},
    // renormalize with a zero sum: every kept weight reads zero
    '{8'd20,  16'd0,     1'b1, 1'b0, 1'b0, '0},
    '{8'd21,  16'd0,     1'b1, 1'b0, 1'b0, '0},
    '{8'd22,  16'd0,     1'b1, 1'b0, 1'b0, '0},
    '{8'd23,  16'd0,     1'b1, 1'b0, 1'b0, '0},
    '{8'd24,  16'd0,     1'b1, 1'b1, 1'b1,
      '{{8'd23, 8'd22, 8'd21, 8'd20}, {16'd0, 16'd0, 16'd0, 16'd0}, 3'd4}},
    // duplicate bone with an empty request in between
    '{8'd3,   16'd1000,  1'b1, 1'b0, 1'b0, '0},
    '{8'd99,  16'd5555,  1'b0, 1'b0, 1'b0, '0},
    '{8'd3,   16'd2000,  1'b1, 1'b1, 1'b0, '0},
    // six influences, the last one large: displaces the smallest, renormalized
    '{8'd30,  16'd1,     1'b1, 1'b0, 1'b0, '0},
    '{8'd31,  16'd2,     1'b1, 1'b0, 1'b0, '0},
    '{8'd32,  16'd3,     1'b1, 1'b0, 1'b0, '0},
    '{8'd33,  16'd4,     1'b1, 1'b0, 1'b0, '0},
    '{8'd34,  16'd5,     1'b1, 1'b0, 1'b0, '0},
    '{8'd35,  16'd65535, 1'b1, 1'b1, 1'b0, '0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [IDX_W-1:0] in_bone_index;
  logic [WGT_W-1:0] in_weight;
  logic             in_has_pair;
  logic             in_last_of_vertex;
  logic             out_valid;
  logic             out_ready;
  logic [IDX_W-1:0] out_index_slot0, out_index_slot1, out_index_slot2, out_index_slot3;
  logic [WGT_W-1:0] out_weight_slot0, out_weight_slot1, out_weight_slot2, out_weight_slot3;
  logic [CNT_W-1:0] out_influence_count;

  top4_bone_weight_selector #(
    .MAX_BONES     (MAX_BONES),
    .MAX_INFLUENCES(MAX_INFL)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_bone_index      (in_bone_index),
    .in_weight          (in_weight),
    .in_has_pair        (in_has_pair),
    .in_last_of_vertex  (in_last_of_vertex),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_index_slot0    (out_index_slot0),
    .out_index_slot1    (out_index_slot1),
    .out_index_slot2    (out_index_slot2),
    .out_index_slot3    (out_index_slot3),
    .out_weight_slot0   (out_weight_slot0),
    .out_weight_slot1   (out_weight_slot1),
    .out_weight_slot2   (out_weight_slot2),
    .out_weight_slot3   (out_weight_slot3),
    .out_influence_count(out_influence_count)
  );

  // Predictor state: the sorted chain of the vertex in progress.
  logic [WGT_W-1:0] kept_wgt  [MAX_INFL] = '{default: '0};
  logic [IDX_W-1:0] kept_bone [MAX_INFL] = '{default: '0};
  int               kept_n     = 0;
  int               pairs_seen = 0;    // saturates at MAX_INFL + 1

  vertex_result_t   pending_vertices [$];   // finished vertices awaiting output
  int               mismatches    = 0;
  int               vertices_out  = 0;
  int               cycle_count   = 0;
  int               reqs_sent     = 0;      // pair or vertex-end requests only
  bit               in_eager      = 1'b0;   // input side runs without gaps

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t ERROR vertex %0d: %s", $time, vertices_out, msg);
  endtask

  // Mostly short waits, now and then one drawn from the wider range; none when eager.
  function automatic int draw_wait(input bit eager);
    if (eager)
      return 0;
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 16);
    return $urandom_range(0, 2);
  endfunction

  // Fold one accepted request into the chain. On the last request of a vertex
  // the result is built: renormalize only after more than MAX_INFL influences.
  task automatic fold_influence(input logic [IDX_W-1:0] bone, input logic [WGT_W-1:0] w,
                                input logic has_pair, input logic end_vtx,
                                output bit done, output vertex_result_t res);
    int          pos;
    bit          renorm;
    logic [31:0] wsum;
    logic [47:0] scaled;
    done = 1'b0;
    res  = '0;
    if (has_pair && int'(bone) < MAX_BONES) begin
      pos = 0;
      // ties stay behind the weights already kept
      while (pos < kept_n && kept_wgt[pos] >= w)
        pos++;
      if (pos < MAX_INFL) begin
        if (kept_n < MAX_INFL)
          kept_n++;
        for (int i = kept_n - 1; i > pos; i--) begin
          kept_wgt[i]  = kept_wgt[i-1];
          kept_bone[i] = kept_bone[i-1];
        end
        kept_wgt[pos]  = w;
        kept_bone[pos] = bone;
      end
      if (pairs_seen <= MAX_INFL)
        pairs_seen++;
    end
    if (end_vtx) begin
      renorm = pairs_seen > MAX_INFL;
      wsum   = '0;
      for (int s = 0; s < kept_n; s++)
        wsum += 32'(kept_wgt[s]);
      for (int s = 0; s < OUT_SLOTS; s++) begin
        if (s < kept_n) begin
          res.idx[s] = kept_bone[s];
          if (!renorm) begin
            res.wgt[s] = kept_wgt[s];
          end else if (wsum == '0) begin
            res.wgt[s] = '0;
          end else begin
            scaled     = (48'(kept_wgt[s]) * 48'(Q15_ONE)) / 48'(wsum);
            res.wgt[s] = scaled[WGT_W-1:0];
          end
        end
      end
      res.cnt = CNT_W'(kept_n < OUT_SLOTS ? kept_n : OUT_SLOTS);
      kept_wgt   = '{default: '0};
      kept_bone  = '{default: '0};
      kept_n     = 0;
      pairs_seen = 0;
      done       = 1'b1;
    end
  endtask

  // Drive one request: idle for a drawn number of cycles, hold valid until
  // accepted, then predict. Called right after the previous acceptance edge.
  task automatic send_request(input logic [IDX_W-1:0] bone, input logic [WGT_W-1:0] w,
                              input logic has_pair, input logic end_vtx,
                              input logic fixed_res, input vertex_result_t typed_res);
    int             gap;
    bit             done;
    vertex_result_t res;
    gap = draw_wait(in_eager);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_bone_index     = bone;
    in_weight         = w;
    in_has_pair       = has_pair;
    in_last_of_vertex = end_vtx;
    do @(posedge clk); while (!in_ready);
    fold_influence(bone, w, has_pair, end_vtx, done, res);
    if (done) begin
      if (fixed_res)
        res = typed_res;
      pending_vertices = {pending_vertices, res};
    end
  endtask

  function automatic logic [WGT_W-1:0] pick_weight(input int wmode);
    case (wmode)
      0:       return WGT_W'($urandom_range(0, 65535));
      1:       return WGT_W'($urandom_range(0, 32768));
      2:       return WGT_W'($urandom_range(0, 7));    // small range, many ties
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return WGT_W'(1);
          2:       return Q15_ONE;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // One random vertex. Most are well formed (ascending bones, 1..8 influences);
  // some are empty, deeper than the chain, unsorted, duplicated, or carry
  // empty requests in the middle or as the closing request.
  task automatic random_vertex();
    int               pick;
    int               n;
    int               wmode;
    bit               end_marker;
    logic [IDX_W-1:0] bones [$];
    pick  = $urandom_range(0, 19);
    wmode = $urandom_range(0, 3);
    if (pick == 0)       n = 0;
    else if (pick < 9)   n = $urandom_range(1, 4);
    else if (pick < 18)  n = $urandom_range(5, 8);
    else                 n = $urandom_range(9, 14);
    for (int k = 0; k < n; k++)
      bones = {bones, IDX_W'($urandom_range(0, 255))};
    if (n > 1 && $urandom_range(0, 7) == 0)
      bones[1] = bones[0];
    if ($urandom_range(0, 9) != 0)
      bones.sort();
    end_marker = (n == 0) || ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 7) == 0)
      in_eager = ~in_eager;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(IDX_W'($urandom), WGT_W'($urandom), 1'b0, 1'b0, 1'b0, '0);
      send_request(bones[k], pick_weight(wmode), 1'b1,
                   (k == n - 1) && !end_marker, 1'b0, '0);
      reqs_sent++;
    end
    if (end_marker) begin
      send_request(IDX_W'($urandom), WGT_W'($urandom), 1'b0, 1'b1, 1'b0, '0);
      reqs_sent++;
    end
  endtask

  // Compare one accepted result with the oldest finished vertex.
  task automatic check_vertex();
    vertex_result_t want;
    vertex_result_t got;
    got.idx = {out_index_slot3, out_index_slot2, out_index_slot1, out_index_slot0};
    got.wgt = {out_weight_slot3, out_weight_slot2, out_weight_slot1, out_weight_slot0};
    got.cnt = out_influence_count;
    if (pending_vertices.size() == 0) begin
      report_mismatch("result with no vertex pending");
    end else begin
      want = pending_vertices.pop_front();
      for (int s = 0; s < OUT_SLOTS; s++) begin
        if (got.idx[s] !== want.idx[s])
          report_mismatch($sformatf("slot %0d index got %0d want %0d",
                                    s, got.idx[s], want.idx[s]));
        if (got.wgt[s] !== want.wgt[s])
          report_mismatch($sformatf("slot %0d weight got %0d want %0d",
                                    s, got.wgt[s], want.wgt[s]));
      end
      if (got.cnt !== want.cnt)
        report_mismatch($sformatf("influence count got %0d want %0d", got.cnt, want.cnt));
    end
    vertices_out++;
  endtask

  // Result side: stall a drawn number of cycles before each result, with
  // stretches where ready stays high throughout.
  initial begin
    int stall;
    bit out_eager;
    out_ready = 1'b0;
    out_eager = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 15) == 0)
        out_eager = ~out_eager;
      stall = draw_wait(out_eager);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      check_vertex();
    end
  end

  // Request side and end of run.
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_bone_index     = '0;
    in_weight         = '0;
    in_has_pair       = 1'b0;
    in_last_of_vertex = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows first: extremes, ties, empty and renormalized vertices
    for (int r = 0; r < N_DIR; r++)
      send_request(DIR_ROWS[r].bone, DIR_ROWS[r].wgt, DIR_ROWS[r].has_pair,
                   DIR_ROWS[r].end_vtx, DIR_ROWS[r].fixed_res, DIR_ROWS[r].res);

    while (reqs_sent < TARGET_REQS)
      random_vertex();

    @(negedge clk);
    in_valid = 1'b0;

    // every vertex has ended, so each pending entry must still show up
    while (pending_vertices.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
